/* rtl/route_decision_cache_ttl_defines.svh */
// assertion macros for the route decision cache checker
`ifndef ROUTE_DECISION_CACHE_TTL_DEFINES_SVH
`define ROUTE_DECISION_CACHE_TTL_DEFINES_SVH

// checked on every edge outside reset
`define RDCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define RDCT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/rdct_pkg.sv */
// types and constants shared by the route decision cache modules
package rdct_pkg;

   localparam logic [31:0] TTL_RESET     = 32'd100;
   localparam logic        ACTION_LOOKUP = 1'b0;
   localparam logic        ACTION_UPDATE = 1'b1;
   localparam logic        REG_TTL       = 1'b0;

   typedef struct packed {
      logic        action;
      logic [39:0] now_ms;
      logic [2:0]  service_kind;
      logic [7:0]  core_number;
      logic [15:0] new_server;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] server_out;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  service;
      logic [7:0]  core;
      logic [15:0] server;
      logic [40:0] expiry;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic write_entry;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic is_update;
      logic rsp_free;
   } dp_status_type;

endpackage

/* rtl/rdct_ram.sv */
// generic single write port, single read port ram with registered read
module rdct_ram #(
   parameter int WIDTH = 68,
   parameter int DEPTH = 16,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rdct_ctrl.sv */
// controller state machine for the route decision cache
module rdct_ctrl
   import rdct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = status.is_update ? ST_WRITE : ST_DONE;
            end
         end
         ST_WRITE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_WRITE: begin
            cmd.write_entry = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/rdct_dp.sv */
// datapath: item register, slot scan, entry write, counters, result register, ttl register
module rdct_dp
   import rdct_pkg::*;
#(
   parameter int CACHE_SLOTS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status
);

   localparam int AW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
   localparam int CW = $clog2(CACHE_SLOTS + 1);
   localparam logic [CW-1:0] SlotCount = CW'(CACHE_SLOTS);

   req_type       item_ff, item_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   logic          found_ff, found_in;
   logic [AW-1:0] found_idx_ff, found_idx_in;
   logic [15:0]   found_server_ff, found_server_in;
   logic [CW-1:0] used_ff, used_in;
   logic [31:0]   hit_cnt_ff, hit_cnt_in;
   logic [31:0]   miss_cnt_ff, miss_cnt_in;
   logic [31:0]   ttl_ff, ttl_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          is_update;
   logic          issue;
   logic          key_eq;
   logic          live;
   logic          match;
   logic          lookup_hit;
   logic          has_room;
   logic [AW-1:0] wr_addr;
   slot_type      wr_entry;
   slot_type      rd_entry;
   logic [$bits(slot_type)-1:0] rd_word;

   assign is_update = (item_ff.action == ACTION_UPDATE);
   assign issue     = cmd.scan && (addr_ff < used_ff) && !found_ff;
   assign rd_entry  = slot_type'(rd_word);
   assign key_eq    = (rd_entry.service == item_ff.service_kind)
                   && (rd_entry.core == item_ff.core_number);
   assign live      = ({1'b0, item_ff.now_ms} < rd_entry.expiry);
   assign match     = pend_ff && key_eq && (is_update || live);
   assign lookup_hit = !is_update && found_ff;
   assign has_room  = (used_ff < SlotCount);

   always_comb begin
      if (found_ff) begin
         wr_addr = found_idx_ff;
      end else if (has_room) begin
         wr_addr = used_ff[AW-1:0];
      end else begin
         wr_addr = '0;
      end
   end

   assign wr_entry.service = item_ff.service_kind;
   assign wr_entry.core    = item_ff.core_number;
   assign wr_entry.server  = item_ff.new_server;
   assign wr_entry.expiry  = {1'b0, item_ff.now_ms} + {9'd0, ttl_ff};

   rdct_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (CACHE_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_word)
   );

   always_comb begin
      item_in         = item_ff;
      addr_in         = addr_ff;
      pend_in         = pend_ff;
      pend_idx_in     = pend_idx_ff;
      found_in        = found_ff;
      found_idx_in    = found_idx_ff;
      found_server_in = found_server_ff;
      used_in         = used_ff;
      hit_cnt_in      = hit_cnt_ff;
      miss_cnt_in     = miss_cnt_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      ttl_in          = ttl_ff;

      if (cmd.start) begin
         item_in  = req_data;
         addr_in  = '0;
         pend_in  = 1'b0;
         found_in = 1'b0;
      end

      if (cmd.scan) begin
         pend_in     = issue;
         pend_idx_in = addr_ff[AW-1:0];
         if (issue) begin
            addr_in = addr_ff + CW'(1);
         end
         if (match && !found_ff) begin
            found_in        = 1'b1;
            found_idx_in    = pend_idx_ff;
            found_server_in = rd_entry.server;
         end
      end

      if (cmd.write_entry && !found_ff && has_room) begin
         used_in = used_ff + CW'(1);
      end

      if (cmd.load_rsp) begin
         if (!is_update) begin
            if (found_ff) begin
               hit_cnt_in = hit_cnt_ff + 32'd1;
            end else begin
               miss_cnt_in = miss_cnt_ff + 32'd1;
            end
         end
         rsp_in.hit        = lookup_hit;
         rsp_in.server_out = lookup_hit ? found_server_ff : 16'd0;
         rsp_in.hit_total  = hit_cnt_in;
         rsp_in.miss_total = miss_cnt_in;
         rsp_valid_in      = 1'b1;
      end

      if (psel && penable && pwrite && (paddr[2] == REG_TTL)) begin
         ttl_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      item_ff         <= item_in;
      addr_ff         <= addr_in;
      pend_idx_ff     <= pend_idx_in;
      found_idx_ff    <= found_idx_in;
      found_server_ff <= found_server_in;
      rsp_ff          <= rsp_in;
      if (reset) begin
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         used_ff      <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         ttl_ff       <= TTL_RESET;
      end else begin
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         used_ff      <= used_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         ttl_ff       <= ttl_in;
      end
   end

   assign status.scan_done = !pend_ff && (found_ff || (addr_ff >= used_ff));
   assign status.is_update = is_update;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign prdata    = (paddr[2] == REG_TTL) ? ttl_ff : 32'd0;

endmodule

/* rtl/route_decision_cache_ttl.sv */
// top level of the route decision cache with entry expiry
//
//   port group   direction   handshake              payload
//   req_         in          req_valid / req_stall  req_data (req_type)
//   rsp_         out         rsp_valid / rsp_stall  rsp_data (rsp_type)
//   apb          in/out      psel penable pready    paddr pwdata prdata (ttl_ms at 0)
//
// an update writes its entry in a write state after the scan, before its result is loaded
// the scan reads one slot per cycle from the slot ram; an earlier match ends it sooner
// the next item is taken in the cycle after the result is loaded
// a new item is taken while the previous result waits in the output register
// a stalled result holds the block in its final state until the result is taken
// synchronous reset empties the cache, clears both counters and sets ttl_ms to 100
module route_decision_cache_ttl
   import rdct_pkg::*;
#(
   parameter int CACHE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rdct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rdct_dp #(
      .CACHE_SLOTS (CACHE_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .cmd       (cmd),
      .status    (status)
   );

   assign pready = 1'b1;

endmodule

/* rtl/rdct_checker.sv */
// port level checks for the route decision cache, bound to the top level
`include "route_decision_cache_ttl_defines.svh"

module rdct_checker
   import rdct_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic rsp_wait;
   logic req_take;
   logic miss_out;

   assign rsp_wait = rsp_valid && rsp_stall;
   assign req_take = req_valid && !req_stall;
   assign miss_out = rsp_valid && !rsp_data.hit;

   `RDCT_ASSERT(a_rsp_hold, rsp_wait |=> rsp_valid && $stable(rsp_data), "stalled item changed")
   `RDCT_ASSERT(a_miss_zero, miss_out |-> rsp_data.server_out == 16'd0, "server id on a miss")
   `RDCT_ASSERT(a_one_at_a_time, req_take |=> req_stall, "item taken while busy")
   `RDCT_ASSERT_ALWAYS(a_reset_state, reset |=> !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind route_decision_cache_ttl rdct_checker u_rdct_checker (.*);

/* tb/route_decision_cache_ttl_tb.sv */
// testbench for the route decision cache: directed and random requests checked against a local cache predictor
`timescale 1ns / 1ps

module route_decision_cache_ttl_tb;
   import rdct_pkg::*;

   localparam int          CACHE_SLOTS  = 16;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 2 * CACHE_SLOTS + 8;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          PRINT_LIMIT  = 100;
   localparam logic [2:0]  TTL_ADDR     = {REG_TTL, 2'b00};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // predictor state
   slot_type    cache_slots [CACHE_SLOTS];
   int          slots_filled;
   logic [31:0] hit_count;
   logic [31:0] miss_count;
   logic [31:0] ttl_value;

   rsp_type     expected_routes [$];
   logic [39:0] traffic_clock;
   int          send_idle_pct;
   int          recv_stall_pct;
   logic        hold_output;
   int          error_count;
   int          requests_sent;
   int          updates_sent;
   int          cycle_count = 0;

   route_decision_cache_ttl #(
      .CACHE_SLOTS(CACHE_SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_routes.size());
         $display("route_decision_cache_ttl_tb: errors");
         $finish;
      end
   end

   function automatic rsp_type resolve_route(input req_type r);
      rsp_type     o;
      int          target;
      bit          found;
      o = '0;
      found = 1'b0;
      target = 0;
      if (r.action == ACTION_LOOKUP) begin
         for (int i = 0; i < slots_filled && !found; i++) begin
            if (cache_slots[i].service == r.service_kind && cache_slots[i].core == r.core_number
                && {1'b0, r.now_ms} < cache_slots[i].expiry) begin
               found = 1'b1;
               o.hit = 1'b1;
               o.server_out = cache_slots[i].server;
            end
         end
         if (found) hit_count = hit_count + 32'd1;
         else miss_count = miss_count + 32'd1;
      end else begin
         for (int i = 0; i < slots_filled && !found; i++) begin
            if (cache_slots[i].service == r.service_kind && cache_slots[i].core == r.core_number) begin
               found = 1'b1;
               target = i;
            end
         end
         if (!found && slots_filled < CACHE_SLOTS) begin
            target = slots_filled;
            slots_filled++;
         end
         cache_slots[target].service = r.service_kind;
         cache_slots[target].core    = r.core_number;
         cache_slots[target].server  = r.new_server;
         cache_slots[target].expiry  = {1'b0, r.now_ms} + {9'd0, ttl_value};
      end
      o.hit_total  = hit_count;
      o.miss_total = miss_count;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_route(input rsp_type got);
      rsp_type want;
      if (expected_routes.size() == 0) begin
         report_mismatch("result with nothing outstanding", 64'(got.server_out), 64'd0);
      end else begin
         want = expected_routes.pop_front();
         if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
         if (got.server_out !== want.server_out)
            report_mismatch("server_out", 64'(got.server_out), 64'(want.server_out));
         if (got.hit_total !== want.hit_total)
            report_mismatch("hit_total", 64'(got.hit_total), 64'(want.hit_total));
         if (got.miss_total !== want.miss_total)
            report_mismatch("miss_total", 64'(got.miss_total), 64'(want.miss_total));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_route(rsp_data);
         rsp_stall <= hold_output || ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic req_type make_request(input logic action, input logic [39:0] now,
                                            input logic [2:0] kind, input logic [7:0] core,
                                            input logic [15:0] server);
      req_type r;
      r.action       = action;
      r.now_ms       = now;
      r.service_kind = kind;
      r.core_number  = core;
      r.new_server   = server;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.new_server = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
      if ($urandom_range(9) == 0) begin
         // noise: any key, any time, time may jump backward
         r.action       = 1'($urandom);
         r.now_ms       = {8'($urandom), 32'($urandom)};
         r.service_kind = 3'($urandom);
         r.core_number  = 8'($urandom);
      end else begin
         traffic_clock  = traffic_clock + 40'($urandom_range(0, 15));
         r.now_ms       = traffic_clock;
         r.action       = ($urandom_range(99) < 35) ? ACTION_UPDATE : ACTION_LOOKUP;
         r.service_kind = 3'($urandom_range(3));
         r.core_number  = 8'($urandom_range(7));
      end
      return r;
   endfunction

   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_routes.push_back(resolve_route(item));
      requests_sent++;
      if (item.action == ACTION_UPDATE) updates_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_routes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] value,
                             output logic [31:0] read_value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= TTL_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      read_value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_ttl(input logic [31:0] value);
      logic [31:0] readback;
      wait_idle();
      csr_access(1'b1, value, readback);
      ttl_value = value;
      csr_access(1'b0, '0, readback);
      if (readback !== ttl_value)
         report_mismatch("ttl_ms readback", 64'(readback), 64'(ttl_value));
   endtask

   task automatic test_csr_reset_value();
      logic [31:0] readback;
      csr_access(1'b0, '0, readback);
      if (readback !== TTL_RESET)
         report_mismatch("ttl_ms after reset", 64'(readback), 64'(TTL_RESET));
   endtask

   task automatic test_expiry_edges();
      send_request(make_request(ACTION_LOOKUP, 40'd0, 3'd0, 8'd0, 16'h0000));
      send_request(make_request(ACTION_UPDATE, 40'd0, 3'd7, 8'd255, 16'hFFFF));
      send_request(make_request(ACTION_LOOKUP, 40'd99, 3'd7, 8'd255, 16'h0000));
      // expiry equal to now counts as expired
      send_request(make_request(ACTION_LOOKUP, 40'd100, 3'd7, 8'd255, 16'h0000));
   endtask

   task automatic test_key_handling();
      send_request(make_request(ACTION_UPDATE, 40'd1000, 3'd0, 8'd0, 16'h0000));
      // stored id of zero still reports a hit
      send_request(make_request(ACTION_LOOKUP, 40'd1000, 3'd0, 8'd0, 16'hFFFF));
      send_request(make_request(ACTION_UPDATE, 40'd2000, 3'd7, 8'd255, 16'h1234));
      send_request(make_request(ACTION_LOOKUP, 40'd2050, 3'd7, 8'd255, 16'h0000));
      send_request(make_request(ACTION_LOOKUP, 40'd2050, 3'd7, 8'd0, 16'h0000));
      send_request(make_request(ACTION_UPDATE, 40'hFF_FFFF_FFFF, 3'd3, 8'h5A, 16'hA5A5));
      send_request(make_request(ACTION_LOOKUP, 40'hFF_FFFF_FFFF, 3'd3, 8'h5A, 16'h0000));
   endtask

   task automatic test_fill_and_evict();
      for (int i = 0; i < CACHE_SLOTS - 3; i++)
         send_request(make_request(ACTION_UPDATE, 40'd3000, 3'(1 + i % 3), 8'(i / 3),
                                   16'(16'h0100 + i)));
      // full cache, new key lands in entry zero
      send_request(make_request(ACTION_UPDATE, 40'd3010, 3'd0, 8'd7, 16'hBEEF));
      send_request(make_request(ACTION_LOOKUP, 40'd3020, 3'd0, 8'd7, 16'h0000));
      send_request(make_request(ACTION_LOOKUP, 40'd3020, 3'd7, 8'd255, 16'h0000));
   endtask

   task automatic test_random_traffic(input logic [31:0] ttl, input int send_pct,
                                      input int recv_pct, input int count);
      configure_ttl(ttl);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) send_request(random_request());
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      configure_ttl(32'd200);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_output <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output <= 1'b0;
         end
      join_none
      repeat (40) send_request(random_request());
      wait_idle();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      hold_output    = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      error_count    = 0;
      requests_sent  = 0;
      updates_sent   = 0;
      slots_filled   = 0;
      hit_count      = '0;
      miss_count     = '0;
      ttl_value      = TTL_RESET;
      traffic_clock  = 40'd5000;
      foreach (cache_slots[i]) cache_slots[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_csr_reset_value();
      test_expiry_edges();
      test_key_handling();
      test_fill_and_evict();
      wait_idle();
      test_random_traffic(32'd60, 0, 0, 160);
      test_random_traffic(32'd0, 80, 0, 160);
      test_random_traffic(32'hFFFF_FFFF, 0, 80, 160);
      test_random_traffic(32'($urandom_range(20, 120)), 23, 23, 160);
      test_output_backpressure();

      $display("summary: %0d requests (%0d updates), %0d lookup hits, %0d lookup misses",
               requests_sent, updates_sent, hit_count, miss_count);
      $display("summary: ttl from 0 to max, four idle mixes, %0d-cycle output hold",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("route_decision_cache_ttl_tb: clean");
      end else begin
         $display("route_decision_cache_ttl_tb: errors");
      end
      $finish;
   end

endmodule
